// ===== rtl/core/dda_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dda_pkg
// Shared constants and controller/datapath signal groups for the DDA line
// rasterizer.
// ----------------------------------------------------------------------------
package dda_pkg;

  localparam int COORD_BITS_DEF = 10;
  localparam int FRAC_BITS_DEF  = 16;

  // Action codes carried by an input item
  localparam logic ACTION_LOAD = 1'b0;
  localparam logic ACTION_STEP = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load;       // latch endpoints, deltas and start position
    logic step;       // emit the next point if a line is active
    logic div_init;   // seed the divider
    logic div_sel_y;  // divider works on the y delta when set
    logic div_iter;   // one quotient bit
    logic store_x;    // write the finished quotient to the x increment
    logic store_y;    // write the finished quotient to the y increment
  } dda_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic steps_zero; // latched line has zero length
    logic div_last;   // divider is on its final quotient bit
    logic out_valid;  // output register holds an item
  } dda_sts_t;

endpackage : dda_pkg
`default_nettype wire

// ===== rtl/core/dda_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dda_if
// Valid/ready channels of the DDA line rasterizer: line commands in, pixels
// out.
// ----------------------------------------------------------------------------
interface dda_in_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] x_start;
  logic [COORD_BITS-1:0] y_start;
  logic [COORD_BITS-1:0] x_end;
  logic [COORD_BITS-1:0] y_end;

  modport source (output valid, action, x_start, y_start, x_end, y_end, input ready);
  modport sink   (input valid, action, x_start, y_start, x_end, y_end, output ready);
endinterface : dda_in_if

interface dda_out_if #(
  parameter int COORD_BITS = 10
);
  logic                  valid;
  logic                  ready;
  logic [COORD_BITS-1:0] pixel_x;
  logic [COORD_BITS-1:0] pixel_y;
  logic                  last_point;

  modport source (output valid, pixel_x, pixel_y, last_point, input ready);
  modport sink   (input valid, pixel_x, pixel_y, last_point, output ready);
endinterface : dda_out_if
`default_nettype wire

// ===== rtl/core/dda_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dda_ctrl
// Sequencer for the rasterizer: accepts items, runs the increment division
// for x and then y after each load of a nonzero-length line.
// ----------------------------------------------------------------------------
module dda_ctrl (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  input  wire logic              in_action,
  output logic                   in_ready,
  input  wire logic              out_ready,
  input  wire dda_pkg::dda_sts_t sts,
  output dda_pkg::dda_cmd_t      cmd
);
  import dda_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SETUP = 2'd1;
  localparam logic [1:0] S_DIV_X = 2'd2;
  localparam logic [1:0] S_DIV_Y = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       in_fire;

  // Take a load at any time in idle; take a step once the output slot frees
  assign in_ready = (state == S_IDLE) &&
                    ((in_action == ACTION_LOAD) || !sts.out_valid || out_ready);
  assign in_fire  = in_valid && in_ready;

  // Decode state into datapath commands
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          if (in_action == ACTION_LOAD) begin
            cmd.load   = 1'b1;
            state_next = S_SETUP;
          end else begin
            cmd.step = 1'b1;
          end
        end
      end
      S_SETUP: begin
        if (sts.steps_zero) begin
          state_next = S_IDLE;
        end else begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV_X;
        end
      end
      S_DIV_X: begin
        cmd.div_iter = 1'b1;
        if (sts.div_last) begin
          cmd.store_x   = 1'b1;
          cmd.div_init  = 1'b1;
          cmd.div_sel_y = 1'b1;
          state_next    = S_DIV_Y;
        end
      end
      S_DIV_Y: begin
        cmd.div_iter  = 1'b1;
        cmd.div_sel_y = 1'b1;
        if (sts.div_last) begin
          cmd.store_y = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule : dda_ctrl
`default_nettype wire

// ===== rtl/core/dda_datapath.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dda_datapath
// Endpoint deltas, a bit-serial restoring divider for the increments, the
// fixed-point accumulators and the output register.
// ----------------------------------------------------------------------------
module dda_datapath #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire dda_pkg::dda_cmd_t     cmd,
  output dda_pkg::dda_sts_t          sts,
  input  wire logic [COORD_BITS-1:0] x_start,
  input  wire logic [COORD_BITS-1:0] y_start,
  input  wire logic [COORD_BITS-1:0] x_end,
  input  wire logic [COORD_BITS-1:0] y_end,
  input  wire logic                  out_ready,
  output logic                       out_valid,
  output logic [COORD_BITS-1:0]      pixel_x,
  output logic [COORD_BITS-1:0]      pixel_y,
  output logic                       last_point
);
  import dda_pkg::*;

  localparam int AW = COORD_BITS + FRAC_BITS;      // accumulator width
  localparam int SW = FRAC_BITS + 2;               // increment width
  localparam int QW = FRAC_BITS + 1;               // quotient width
  localparam int NW = COORD_BITS + FRAC_BITS + 2;  // dividend width
  localparam int CW = $clog2(QW);                  // iteration counter width
  localparam logic [AW-1:0] HALF = AW'(1) << (FRAC_BITS - 1);

  logic [AW-1:0]         x_accum;
  logic [AW-1:0]         y_accum;
  logic [SW-1:0]         x_step;
  logic [SW-1:0]         y_step;
  logic [COORD_BITS:0]   points_left;
  logic                  line_active;
  logic [COORD_BITS-1:0] x_mag;
  logic [COORD_BITS-1:0] y_mag;
  logic                  x_neg;
  logic                  y_neg;
  logic [COORD_BITS-1:0] steps;
  logic [COORD_BITS:0]   rem;
  logic [QW-1:0]         quo;
  logic [CW-1:0]         cnt;

  logic [COORD_BITS-1:0] dx_mag;
  logic [COORD_BITS-1:0] dy_mag;
  logic [COORD_BITS-1:0] d_steps;
  logic [COORD_BITS-1:0] mag_sel;
  logic [NW-1:0]         dividend;
  logic [COORD_BITS:0]   divisor;
  logic [COORD_BITS+1:0] trial;
  logic [COORD_BITS+1:0] trial_diff;
  logic                  trial_ge;
  logic [COORD_BITS:0]   rem_next;
  logic [QW-1:0]         quo_next;
  logic [SW-1:0]         q_ext;
  logic [SW-1:0]         q_x;
  logic [SW-1:0]         q_y;
  logic [AW-1:0]         x_inc;
  logic [AW-1:0]         y_inc;
  logic [AW-1:0]         x_round;
  logic [AW-1:0]         y_round;
  logic                  emit;

  // Absolute deltas and step count from the incoming endpoints
  assign dx_mag  = (x_end > x_start) ? (x_end - x_start) : (x_start - x_end);
  assign dy_mag  = (y_end > y_start) ? (y_end - y_start) : (y_start - y_end);
  assign d_steps = (dx_mag > dy_mag) ? dx_mag : dy_mag;

  // Divider: (2*mag*2^F + steps) / (2*steps), one quotient bit a cycle
  assign mag_sel    = cmd.div_sel_y ? y_mag : x_mag;
  assign dividend   = {1'b0, mag_sel, {QW{1'b0}}} + {{(NW-COORD_BITS){1'b0}}, steps};
  assign divisor    = {steps, 1'b0};
  assign trial      = {rem, quo[QW-1]};
  assign trial_ge   = trial >= {1'b0, divisor};
  assign trial_diff = trial - {1'b0, divisor};
  assign rem_next   = trial_ge ? trial_diff[COORD_BITS:0] : trial[COORD_BITS:0];
  assign quo_next   = {quo[QW-2:0], trial_ge};

  // Apply the delta sign to the finished quotient
  assign q_ext = {1'b0, quo_next};
  assign q_x   = x_neg ? (~q_ext + SW'(1)) : q_ext;
  assign q_y   = y_neg ? (~q_ext + SW'(1)) : q_ext;

  // Sign-extend the increments to accumulator width
  assign x_inc = {{(AW-SW){x_step[SW-1]}}, x_step};
  assign y_inc = {{(AW-SW){y_step[SW-1]}}, y_step};

  // Round half up
  assign x_round = x_accum + HALF;
  assign y_round = y_accum + HALF;

  assign emit = cmd.step && line_active;

  assign sts.steps_zero = (steps == '0);
  assign sts.div_last   = (cnt == CW'(QW - 1));
  assign sts.out_valid  = out_valid;

  // Latch the line on load
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_mag <= dx_mag;
      y_mag <= dy_mag;
      x_neg <= x_end < x_start;
      y_neg <= y_end < y_start;
      steps <= d_steps;
    end
  end

  // Run the divider
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (cmd.div_init) begin
      rem <= dividend[NW-1:QW];
      quo <= dividend[QW-1:0];
      cnt <= '0;
    end else if (cmd.div_iter) begin
      rem <= rem_next;
      quo <= quo_next;
      cnt <= cnt + CW'(1);
    end
  end

  // Hold the increments
  always_ff @(posedge clk) begin
    if (rst) begin
      x_step <= '0;
      y_step <= '0;
    end else if (cmd.load) begin
      x_step <= '0;
      y_step <= '0;
    end else begin
      if (cmd.store_x) begin
        x_step <= q_x;
      end
      if (cmd.store_y) begin
        y_step <= q_y;
      end
    end
  end

  // Advance the accumulators and the point count
  always_ff @(posedge clk) begin
    if (rst) begin
      line_active <= 1'b0;
      points_left <= '0;
      x_accum     <= '0;
      y_accum     <= '0;
    end else if (cmd.load) begin
      line_active <= 1'b1;
      points_left <= {1'b0, d_steps} + (COORD_BITS+1)'(1);
      x_accum     <= {x_start, {FRAC_BITS{1'b0}}};
      y_accum     <= {y_start, {FRAC_BITS{1'b0}}};
    end else if (emit) begin
      points_left <= points_left - (COORD_BITS+1)'(1);
      if (points_left == (COORD_BITS+1)'(1)) begin
        line_active <= 1'b0;
      end
      x_accum <= x_accum + x_inc;
      y_accum <= y_accum + y_inc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      pixel_x    <= x_round[AW-1:FRAC_BITS];
      pixel_y    <= y_round[AW-1:FRAC_BITS];
      last_point <= (points_left == (COORD_BITS+1)'(1));
    end
  end

endmodule : dda_datapath
`default_nettype wire

// ===== rtl/core/dda_line_rasterizer.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dda_line_rasterizer
// Step item: while a line is active, the next point is registered into the
//   output register on acceptance; one item per cycle while the output drains.
// Load item: no further item is taken during setup and, for a line of nonzero
//   length, while the bit-serial divider runs the x and then the y increment.
// Reset (synchronous): no line active, output empty, controller idle.
// ----------------------------------------------------------------------------
module dda_line_rasterizer #(
  parameter int COORD_BITS = dda_pkg::COORD_BITS_DEF,
  parameter int FRAC_BITS  = dda_pkg::FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  dda_in_if.sink    line_in,
  dda_out_if.source pixel_out
);
  import dda_pkg::*;

  dda_cmd_t cmd;
  dda_sts_t sts;

  // Sequence items and division
  dda_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (line_in.valid),
    .in_action (line_in.action),
    .in_ready  (line_in.ready),
    .out_ready (pixel_out.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Arithmetic and output register
  dda_datapath #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .sts        (sts),
    .x_start    (line_in.x_start),
    .y_start    (line_in.y_start),
    .x_end      (line_in.x_end),
    .y_end      (line_in.y_end),
    .out_ready  (pixel_out.ready),
    .out_valid  (pixel_out.valid),
    .pixel_x    (pixel_out.pixel_x),
    .pixel_y    (pixel_out.pixel_y),
    .last_point (pixel_out.last_point)
  );

endmodule : dda_line_rasterizer
`default_nettype wire
